// ===== rtl/dsa_pkg.sv =====
// Shared types for the table-driven string acceptor.
// Holds the command codes, controller states and the control/status structs.
// No dependencies.
package dsa_pkg;

	// Request command codes
	typedef enum logic [2:0] {
		CMD_TRANS  = 3'd0,
		CMD_ACCEPT = 3'd1,
		CMD_MAP    = 3'd2,
		CMD_FEED   = 3'd3,
		CMD_END    = 3'd4
	} dsa_op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_TRANS,
		ST_END
	} dsa_state_t;

	// Fixed field widths of a request
	localparam int CmdW   = 3;
	localparam int StateW = 6;
	localparam int SymW   = 4;
	localparam int CharW  = 8;
	localparam int MapDepth = 1 << CharW;

	// Controller to datapath
	typedef struct packed {
		logic clear;      // clearing sweep running
		logic take;       // request accepted this cycle
		logic map_chk;    // symbol map data is on the RAM output
		logic trans_upd;  // transition data is on the RAM output
		logic end_load;   // load the result register
	} dsa_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_done; // last entry of the clearing sweep
		logic map_live;   // run live and character mapped
		logic out_free;   // result register can take a new result
	} dsa_sts_t;

endpackage

// ===== rtl/dsa_ram.sv =====
// Generic single-port RAM with registered read and read/write enable.
// No dependencies.
module dsa_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Write and read at one address; read data holds when disabled
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/dsa_ctrl.sv =====
// Controller of the string acceptor: sequences clearing, lookups and results.
// Depends on dsa_pkg.
module dsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2:0]        in_command,
	output logic              in_ready,
	input  dsa_pkg::dsa_sts_t sts,
	output dsa_pkg::dsa_cmd_t cmd
);
	import dsa_pkg::*;

	dsa_state_t state_q, state_d;
	logic       take;

	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_TRANS);
	assign take     = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.sweep_done) state_d = ST_IDLE;
			end
			ST_IDLE, ST_TRANS: begin
				if (take && in_command == CMD_FEED) begin
					state_d = ST_MAP;
				end else if (take && in_command == CMD_END) begin
					state_d = ST_END;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MAP: begin
				state_d = sts.map_live ? ST_TRANS : ST_IDLE;
			end
			ST_END: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd.clear     = (state_q == ST_CLEAR);
		cmd.take      = take;
		cmd.map_chk   = (state_q == ST_MAP);
		cmd.trans_upd = (state_q == ST_TRANS);
		cmd.end_load  = (state_q == ST_END) && sts.out_free;
	end

endmodule

// ===== rtl/dsa_dpath.sv =====
// Datapath of the string acceptor: tables, run state and result register.
// Depends on dsa_pkg and dsa_ram.
module dsa_dpath #(
	parameter int MAX_STATES  = 64,
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dsa_pkg::dsa_cmd_t         cmd,
	output dsa_pkg::dsa_sts_t         sts,
	input  logic                      cfg_we,
	input  logic [dsa_pkg::StateW-1:0] cfg_wdata,
	input  logic [dsa_pkg::CmdW-1:0]   command,
	input  logic [dsa_pkg::StateW-1:0] state_index,
	input  logic [dsa_pkg::SymW-1:0]   symbol_index,
	input  logic [dsa_pkg::StateW-1:0] target_state,
	input  logic                      target_dead,
	input  logic                      flag_value,
	input  logic [dsa_pkg::CharW-1:0]  char_code,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      accepted
);
	import dsa_pkg::*;

	localparam int RowW = ($clog2(MAX_STATES) < StateW) ? $clog2(MAX_STATES) : StateW;
	localparam int ColW = ($clog2(MAX_SYMBOLS) < SymW) ? $clog2(MAX_SYMBOLS) : SymW;
	localparam int TrAw = RowW + ColW;
	localparam int TrDepth = 1 << TrAw;
	localparam int FlDepth = 1 << RowW;
	localparam int ClrW = (TrAw > CharW) ? TrAw : CharW;

	// Run state and registers
	logic [StateW-1:0] init_q;
	logic [RowW-1:0]   cur_q;
	logic              dead_q;
	logic              start_q;
	logic              end_live_q;
	logic              out_valid_q;
	logic              acc_q;
	logic [ClrW-1:0]   clr_q;

	// RAM ports
	logic              map_en, map_we;
	logic [CharW-1:0]  map_addr;
	logic [ColW:0]     map_wdata, map_rdata;
	logic              tr_en, tr_we;
	logic [TrAw-1:0]   tr_addr;
	logic [RowW:0]     tr_wdata, tr_rdata;
	logic              fl_en, fl_we;
	logic [RowW-1:0]   fl_addr;
	logic              fl_wdata, fl_rdata;

	logic              is_trans, is_accept, is_map, is_feed, is_end;
	logic              row_ok, col_ok, tgt_ok, init_ok, sym_ok;
	logic [RowW-1:0]   st_next;
	logic              dead_next;

	assign is_trans  = cmd.take && command == CMD_TRANS;
	assign is_accept = cmd.take && command == CMD_ACCEPT;
	assign is_map    = cmd.take && command == CMD_MAP;
	assign is_feed   = cmd.take && command == CMD_FEED;
	assign is_end    = cmd.take && command == CMD_END;

	assign row_ok  = 32'(state_index) < 32'(MAX_STATES);
	assign col_ok  = 32'(symbol_index) < 32'(MAX_SYMBOLS);
	assign sym_ok  = col_ok;
	assign tgt_ok  = 32'(target_state) < 32'(MAX_STATES);
	assign init_ok = 32'(init_q) < 32'(MAX_STATES);

	// State the run stands in after any lookup finishing this cycle
	always_comb begin
		if (start_q) begin
			st_next   = init_q[RowW-1:0];
			dead_next = !init_ok;
		end else if (cmd.trans_upd) begin
			st_next   = tr_rdata[RowW] ? tr_rdata[RowW-1:0] : cur_q;
			dead_next = dead_q || !tr_rdata[RowW];
		end else begin
			st_next   = cur_q;
			dead_next = dead_q;
		end
	end

	// Symbol map: character to symbol column
	always_comb begin
		map_en    = cmd.clear || is_map || is_feed;
		map_we    = cmd.clear || is_map;
		map_addr  = cmd.clear ? clr_q[CharW-1:0] : char_code;
		map_wdata = '0;
		if (!cmd.clear && flag_value && sym_ok) begin
			map_wdata = {1'b1, symbol_index[ColW-1:0]};
		end
	end

	// Transition store: {row, column} addressing
	always_comb begin
		tr_en    = cmd.clear || is_trans || (cmd.map_chk && sts.map_live);
		tr_we    = cmd.clear || (is_trans && row_ok && col_ok);
		tr_wdata = '0;
		if (cmd.clear) begin
			tr_addr = clr_q[TrAw-1:0];
		end else if (cmd.map_chk) begin
			tr_addr = {cur_q, map_rdata[ColW-1:0]};
		end else begin
			tr_addr = {state_index[RowW-1:0], symbol_index[ColW-1:0]};
		end
		if (!cmd.clear && !target_dead && tgt_ok) begin
			tr_wdata = {1'b1, target_state[RowW-1:0]};
		end
	end

	// Accept flags
	always_comb begin
		fl_en    = cmd.clear || is_accept || is_end;
		fl_we    = cmd.clear || (is_accept && row_ok);
		fl_wdata = !cmd.clear && flag_value;
		if (cmd.clear) begin
			fl_addr = clr_q[RowW-1:0];
		end else if (is_end) begin
			fl_addr = st_next;
		end else begin
			fl_addr = state_index[RowW-1:0];
		end
	end

	dsa_ram #(.Width(ColW + 1), .Depth(MapDepth)) u_map (
		.clk   (clk),
		.en    (map_en),
		.we    (map_we),
		.addr  (map_addr),
		.wdata (map_wdata),
		.rdata (map_rdata)
	);

	dsa_ram #(.Width(RowW + 1), .Depth(TrDepth)) u_trans (
		.clk   (clk),
		.en    (tr_en),
		.we    (tr_we),
		.addr  (tr_addr),
		.wdata (tr_wdata),
		.rdata (tr_rdata)
	);

	dsa_ram #(.Width(1), .Depth(FlDepth)) u_flags (
		.clk   (clk),
		.en    (fl_en),
		.we    (fl_we),
		.addr  (fl_addr),
		.wdata (fl_wdata),
		.rdata (fl_rdata)
	);

	// Start state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
		end else if (cfg_we) begin
			init_q <= cfg_wdata;
		end
	end

	// Clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Run state: later assignments take precedence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			dead_q  <= 1'b0;
			start_q <= 1'b1;
		end else begin
			// advance on a finished transition lookup
			if (cmd.trans_upd) begin
				if (tr_rdata[RowW]) begin
					cur_q <= tr_rdata[RowW-1:0];
				end else begin
					dead_q <= 1'b1;
				end
			end
			// drop into the dead state on an unmapped character
			if (cmd.map_chk && !dead_q && !map_rdata[ColW]) begin
				dead_q <= 1'b1;
			end
			// begin a run on its first character
			if (is_feed && start_q) begin
				cur_q   <= init_q[RowW-1:0];
				dead_q  <= !init_ok;
				start_q <= 1'b0;
			end
			// end of string: the next character starts afresh
			if (is_end) begin
				dead_q  <= 1'b0;
				start_q <= 1'b1;
			end
		end
	end

	// Liveness of the run at the end request
	always_ff @(posedge clk) begin
		if (is_end) begin
			end_live_q <= !dead_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.end_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.end_load) begin
			acc_q <= end_live_q && fl_rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = acc_q;

	// Status to the controller
	always_comb begin
		sts.sweep_done = &clr_q;
		sts.map_live   = !dead_q && map_rdata[ColW];
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ===== rtl/dfa_string_acceptor_top.sv =====
// Channel   Handshake            Payload
// in        in_valid/in_ready    command, state_index, symbol_index, target_state,
//                                target_dead, flag_value, char_code
// out       out_valid/out_ready  accepted
// cfg       cfg_we               cfg_wdata (start state)
//
// A character runs a symbol map read, then a transition read whose result the
// next request's lookup depends on. An end request reads the accept flag and
// holds off further requests while an earlier result waits to be taken.
// After reset a clearing sweep empties the tables; no request is taken meanwhile.
// Depends on dsa_pkg, dsa_ctrl, dsa_dpath and dsa_ram.
module dfa_string_acceptor_top #(
	parameter int MAX_STATES  = 64,
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dsa_pkg::StateW-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dsa_pkg::CmdW-1:0]   command,
	input  logic [dsa_pkg::StateW-1:0] state_index,
	input  logic [dsa_pkg::SymW-1:0]   symbol_index,
	input  logic [dsa_pkg::StateW-1:0] target_state,
	input  logic                       target_dead,
	input  logic                       flag_value,
	input  logic [dsa_pkg::CharW-1:0]  char_code,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       accepted
);
	import dsa_pkg::*;

	dsa_cmd_t ctl_cmd;
	dsa_sts_t dp_sts;

	dsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (command),
		.in_ready   (in_ready),
		.sts        (dp_sts),
		.cmd        (ctl_cmd)
	);

	dsa_dpath #(
		.MAX_STATES  (MAX_STATES),
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (dp_sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.command      (command),
		.state_index  (state_index),
		.symbol_index (symbol_index),
		.target_state (target_state),
		.target_dead  (target_dead),
		.flag_value   (flag_value),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted)
	);

endmodule

// ===== dv/dfa_string_acceptor_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for dfa_string_acceptor_top: loads small automata, feeds strings under random
// valid/ready gaps and checks every verdict against a predictor held in a scoreboard class.
// Depends on dsa_pkg and the RTL of dfa_string_acceptor_top.
module dfa_string_acceptor_top_tb;
	import dsa_pkg::*;

	localparam int StateCount   = 64;
	localparam int SymbolCount  = 16;
	localparam int CharCount    = MapDepth;
	localparam logic [CmdW-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CmdW-1:0] CMD_SPARE_LAST  = 3'd7;
	localparam int SettleCycles = 8;
	localparam int HoldCycles   = 400;
	localparam int DrainCycles  = 20;
	localparam int PhaseItems   = 170;

	typedef struct packed {
		logic [CmdW-1:0]   command;
		logic [StateW-1:0] state_index;
		logic [SymW-1:0]   symbol_index;
		logic [StateW-1:0] target_state;
		logic              target_dead;
		logic              flag_value;
		logic [CharW-1:0]  char_code;
	} request_t;
	localparam int ReqBits = $bits(request_t);

	typedef struct packed {
		logic              live;
		logic [StateW-1:0] dest;
	} trans_entry_t;

	typedef struct packed {
		logic            valid;
		logic [SymW-1:0] sym;
	} map_entry_t;

	// Predict the verdict of every string from the tables, map and start register
	class acceptor_model;
		trans_entry_t      trans_tab[StateCount][SymbolCount];
		logic              accept_tab[StateCount];
		map_entry_t        char_map[CharCount];
		logic [StateW-1:0] start_state;
		logic [StateW-1:0] cur_state;
		bit                run_dead;
		bit                at_start;
		bit                verdict_q[$];
		int                failures;

		function new();
			foreach (trans_tab[i, j]) trans_tab[i][j] = '0;
			foreach (accept_tab[i]) accept_tab[i] = 1'b0;
			foreach (char_map[i]) char_map[i] = '0;
			start_state = '0;
			cur_state   = '0;
			run_dead    = 1'b0;
			at_start    = 1'b1;
			failures    = 0;
		endfunction

		function void set_start(logic [StateW-1:0] value);
			start_state = value;
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction

		// Latch the start state on the first character or on an empty string
		function void open_run();
			if (at_start) begin
				cur_state = start_state;
				run_dead  = 1'b0;
				at_start  = 1'b0;
			end
		endfunction

		function void note_request(request_t r);
			map_entry_t   m;
			trans_entry_t e;
			case (r.command)
				CMD_TRANS:
					trans_tab[r.state_index][r.symbol_index] = {~r.target_dead, r.target_state};
				CMD_ACCEPT:
					accept_tab[r.state_index] = r.flag_value;
				CMD_MAP:
					char_map[r.char_code] = r.flag_value ? {1'b1, r.symbol_index} : '0;
				CMD_FEED: begin
					open_run();
					m = char_map[r.char_code];
					e = trans_tab[cur_state][m.sym];
					// Drop into the dead state for good on a missing map or table entry
					if (!m.valid || !e.live)
						run_dead = 1'b1;
					else if (!run_dead)
						cur_state = e.dest;
				end
				CMD_END: begin
					open_run();
					verdict_q.insert(verdict_q.size(), !run_dead && accept_tab[cur_state]);
					at_start = 1'b1;
					run_dead = 1'b0;
				end
				default: ;
			endcase
		endfunction

		function void check_verdict(logic got);
			bit want;
			if (verdict_q.size() == 0) begin
				$error("accepted: expected no result, actual %0b", got);
				failures++;
				return;
			end
			want = verdict_q.pop_front();
			if (got !== want) begin
				$error("accepted: expected %0b, actual %0b", want, got);
				failures++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [StateW-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [CmdW-1:0]   command;
	logic [StateW-1:0] state_index;
	logic [SymW-1:0]   symbol_index;
	logic [StateW-1:0] target_state;
	logic              target_dead;
	logic              flag_value;
	logic [CharW-1:0]  char_code;
	logic              out_valid;
	logic              out_ready;
	logic              accepted;

	acceptor_model board;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            items_sent = 0;
	int            hold_asks = 0;

	dfa_string_acceptor_top #(
		.MAX_STATES (StateCount),
		.MAX_SYMBOLS(SymbolCount)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.state_index (state_index),
		.symbol_index(symbol_index),
		.target_state(target_state),
		.target_dead (target_dead),
		.flag_value  (flag_value),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accepted    (accepted)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("dfa_string_acceptor_top_tb NOT OK");
		$finish;
	end

	// Take results; hold off for a long stretch when asked
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_verdict(accepted);
			if (hold_asks != hold_seen) begin
				hold_left = HoldCycles;
				hold_seen = hold_asks;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Random request with the given command; fields it ignores stay random
	function automatic request_t pick(logic [CmdW-1:0] cmd);
		request_t r;
		r = ReqBits'($urandom);
		r.command = cmd;
		return r;
	endfunction

	task automatic send_request(request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= r.command;
		state_index  <= r.state_index;
		symbol_index <= r.symbol_index;
		target_state <= r.target_state;
		target_dead  <= r.target_dead;
		flag_value   <= r.flag_value;
		char_code    <= r.char_code;
		do @(posedge clk); while (!in_ready);
		board.note_request(r);
		items_sent++;
	endtask

	task automatic load_trans(logic [StateW-1:0] row, logic [SymW-1:0] col,
			logic [StateW-1:0] dest, logic dead);
		request_t r;
		r = pick(CMD_TRANS);
		r.state_index  = row;
		r.symbol_index = col;
		r.target_state = dest;
		r.target_dead  = dead;
		send_request(r);
	endtask

	task automatic load_accept(logic [StateW-1:0] row, logic flag);
		request_t r;
		r = pick(CMD_ACCEPT);
		r.state_index = row;
		r.flag_value  = flag;
		send_request(r);
	endtask

	task automatic load_map(logic [CharW-1:0] ch, logic [SymW-1:0] col, logic valid);
		request_t r;
		r = pick(CMD_MAP);
		r.char_code    = ch;
		r.symbol_index = col;
		r.flag_value   = valid;
		send_request(r);
	endtask

	task automatic feed(logic [CharW-1:0] ch);
		request_t r;
		r = pick(CMD_FEED);
		r.char_code = ch;
		send_request(r);
	endtask

	task automatic finish_string();
		send_request(pick(CMD_END));
	endtask

	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Write the start register once the block has gone quiet
	task automatic write_start(logic [StateW-1:0] value);
		in_valid <= 1'b0;
		wait_drained();
		repeat (SettleCycles) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		board.set_start(value);
		cfg_we <= 1'b0;
	endtask

	// Build a small automaton around the start state, then run strings through it
	task automatic run_phase(int send_pct, int recv_pct, logic [StateW-1:0] start, bit squeeze);
		logic [StateW-1:0] states[6];
		logic [SymW-1:0]   syms[4];
		logic [CharW-1:0]  chars[6];
		int                stop_at;
		int                roll;
		write_start(start);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = items_sent + PhaseItems;
		states[0] = start;
		for (int i = 1; i < 6; i++) states[i] = StateW'($urandom);
		foreach (syms[j]) syms[j] = SymW'($urandom);
		foreach (chars[k]) chars[k] = CharW'($urandom);

		foreach (states[i]) begin
			load_accept(states[i], 1'($urandom_range(1)));
			foreach (syms[j])
				load_trans(states[i], syms[j], states[$urandom_range(5)],
					$urandom_range(99) < 12);
		end
		foreach (chars[k])
			load_map(chars[k], syms[$urandom_range(3)], $urandom_range(9) != 0);

		// Stall the result side while ends keep coming, so the block backs up
		if (squeeze) begin
			hold_asks++;
			repeat (24) finish_string();
		end

		while (items_sent < stop_at) begin
			repeat ($urandom_range(6)) begin
				roll = $urandom_range(99);
				if (roll < 8)
					send_request(pick(CmdW'($urandom_range(CMD_SPARE_LAST, CMD_TRANS))));
				else if (roll < 15)
					feed(CharW'($urandom));
				else
					feed(chars[$urandom_range(5)]);
			end
			// Leave the odd string open so it runs on into the next one
			if ($urandom_range(9) != 0)
				finish_string();
		end
	endtask

	initial begin
		board = new();
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		in_valid     <= 1'b0;
		command      <= CMD_TRANS;
		state_index  <= '0;
		symbol_index <= '0;
		target_state <= '0;
		target_dead  <= 1'b0;
		flag_value   <= 1'b0;
		char_code    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty strings, extremes of the tables, dead and unfilled entries
		send_idle_pct = 7;
		recv_idle_pct = 61;
		write_start('0);
		finish_string();
		load_accept(0, 1);
		finish_string();
		load_map(8'h00, 4'hF, 1);
		load_map(8'hFF, 4'h0, 1);
		load_trans(0, 15, 63, 0);
		load_trans(63, 0, 0, 0);
		load_accept(63, 1);
		feed(8'h00);
		feed(8'hFF);
		finish_string();
		feed(8'h5A);
		finish_string();
		load_trans(0, 15, 63, 1);
		feed(8'h00);
		finish_string();
		feed(8'hFF);
		finish_string();
		// Table write in the middle of a string takes effect at once
		load_trans(0, 15, 63, 0);
		feed(8'h00);
		load_accept(63, 0);
		finish_string();
		// Start register rewritten while a string is open leaves that string alone
		feed(8'h00);
		write_start(6'd63);
		feed(8'hFF);
		finish_string();
		send_request(pick(CMD_SPARE_FIRST));
		send_request(pick(CMD_SPARE_LAST));
		finish_string();

		run_phase(7, 61, StateW'($urandom_range(62, 1)), 1'b0);
		run_phase(61, 7, '0, 1'b0);
		run_phase(0, 0, 6'd63, 1'b1);

		in_valid <= 1'b0;
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("dfa_string_acceptor_top_tb OK");
		else
			$display("dfa_string_acceptor_top_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dsa_pkg.sv
rtl/dsa_ram.sv
rtl/dsa_ctrl.sv
rtl/dsa_dpath.sv
rtl/dfa_string_acceptor_top.sv
dv/dfa_string_acceptor_top_tb.sv
